// ===== hw/rtl/pswe_pkg.sv =====
// Package for the protobuf scalar wire encoder.
// Holds the mode codes, sequencer states, widths and unit result types.
// No dependencies.
package pswe_pkg;

    localparam int unsigned MODE_W  = 3;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned FNUM_W  = 32;
    localparam int unsigned WT_W    = 3;
    localparam int unsigned COUNT_W = 32;
    // Longest encoding is ten varint bytes.
    localparam int unsigned LEN_W   = 4;

    localparam logic [MODE_W-1:0] MODE_VARINT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SVARINT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIXED32 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIXED64 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TAG     = 3'd4;

    localparam logic [LEN_W-1:0] LEN_FIXED32 = 4'd4;
    localparam logic [LEN_W-1:0] LEN_FIXED64 = 4'd8;

    localparam logic [7:0] GROUP_MASK = 8'h7F;
    localparam logic [7:0] CONT_BIT   = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_CHECK,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               more;
        logic [VALUE_W-1:0] rest;
    } shift_res_t;

endpackage

// ===== hw/rtl/pswe_shift.sv =====
// Shared shift unit of the wire encoder: peels one output byte off the work word.
// Used both to size a varint and to emit its bytes. Depends on pswe_pkg.
module pswe_shift
    import pswe_pkg::*;
(
    input  logic [VALUE_W-1:0] word,
    input  logic               is_varint,
    output shift_res_t         res
);

    logic more_groups;

    assign more_groups = |word[VALUE_W-1:7];

    always_comb begin
        if (is_varint) begin
            res.more      = more_groups;
            res.data_byte = (word[7:0] & GROUP_MASK) | (more_groups ? CONT_BIT : 8'h00);
            res.rest      = word >> 7;
        end else begin
            // Fixed formats: the byte counter decides when to stop.
            res.more      = 1'b0;
            res.data_byte = word[7:0];
            res.rest      = word >> 8;
        end
    end

endmodule

// ===== hw/rtl/pswe_cap.sv =====
// Capacity check of the wire encoder: one add and one compare.
// Flags an encoding that wraps the byte count or passes the capacity. Depends on pswe_pkg.
module pswe_cap
    import pswe_pkg::*;
(
    input  logic [COUNT_W-1:0] count,
    input  logic [LEN_W-1:0]   len,
    input  logic [COUNT_W-1:0] capacity,
    output logic               fail
);

    logic [COUNT_W:0] sum;

    assign sum  = {1'b0, count} + {{(COUNT_W + 1 - LEN_W){1'b0}}, len};
    assign fail = sum[COUNT_W] | (sum[COUNT_W-1:0] > capacity);

endmodule

// ===== hw/rtl/protobuf_scalar_wire_encoder.sv =====
// Protobuf scalar wire encoder, top level: sequencer, output register and byte count.
// A varint is first sized (ST_SIZE), then checked against the capacity (ST_CHECK), then
// emitted byte by byte (ST_EMIT); fixed32/fixed64 skip sizing. The single shift unit first
// sizes and then emits the encoding, so a new item is taken only once the last is through;
// output backpressure stalls emitting. A failed check leads to ST_ERR instead. Reset
// (aresetn low, synchronous) clears the byte count, sets capacity to all ones and
// empties the output register.
module protobuf_scalar_wire_encoder
    import pswe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [VALUE_W-1:0] s_value,
    input  logic [FNUM_W-1:0]  s_field_number,
    input  logic [WT_W-1:0]    s_wire_type,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last,
    output logic               m_full_error,
    output logic [COUNT_W-1:0] m_total_written
);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] capacity_reg, capacity_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [VALUE_W-1:0] op_reg, op_next;
    logic [VALUE_W-1:0] work_reg, work_next;
    logic               varint_reg, varint_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic               fail_reg, fail_next;

    logic               m_valid_reg, m_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               last_reg, last_next;
    logic               full_error_reg, full_error_next;
    logic [COUNT_W-1:0] total_reg, total_next;

    shift_res_t shift_res;
    logic       cap_fail;
    logic       slot_free;
    logic [VALUE_W-1:0] zigzag;
    logic [VALUE_W-1:0] tag_word;

    pswe_shift u_shift (
        .word      (work_reg),
        .is_varint (varint_reg),
        .res       (shift_res)
    );

    pswe_cap u_cap (
        .count    (count_reg),
        .len      (len_reg),
        .capacity (capacity_reg),
        .fail     (cap_fail)
    );

    assign zigzag   = {s_value[VALUE_W-2:0], 1'b0} ^ {VALUE_W{s_value[VALUE_W-1]}};
    assign tag_word = {{(VALUE_W - FNUM_W - WT_W){1'b0}}, s_field_number, s_wire_type};

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        capacity_next   = cfg_wr_en ? cfg_wr_data : capacity_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        work_next       = work_reg;
        varint_next     = varint_reg;
        len_next        = len_reg;
        rem_next        = rem_reg;
        fail_next       = fail_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        full_error_next = full_error_reg;
        total_next      = total_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    varint_next = 1'b1;
                    len_next    = {{(LEN_W - 1){1'b0}}, 1'b1};
                    state_next  = ST_SIZE;
                    case (s_mode)
                        MODE_VARINT:  op_next = s_value;
                        MODE_SVARINT: op_next = zigzag;
                        MODE_TAG:     op_next = tag_word;
                        MODE_FIXED32: begin
                            op_next     = {{(VALUE_W - 32){1'b0}}, s_value[31:0]};
                            varint_next = 1'b0;
                            len_next    = LEN_FIXED32;
                            state_next  = ST_CHECK;
                        end
                        MODE_FIXED64: begin
                            op_next     = s_value;
                            varint_next = 1'b0;
                            len_next    = LEN_FIXED64;
                            state_next  = ST_CHECK;
                        end
                        // Undefined modes are dropped without a result.
                        default: state_next = ST_IDLE;
                    endcase
                    work_next = op_next;
                end
            end
            ST_SIZE: begin
                if (shift_res.more) begin
                    work_next = shift_res.rest;
                    len_next  = len_reg + 1'b1;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                fail_next  = cap_fail;
                work_next  = op_reg;
                rem_next   = len_reg;
                state_next = cap_fail ? ST_ERR : ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next    = 1'b1;
                    out_byte_next   = shift_res.data_byte;
                    last_next       = (rem_reg == {{(LEN_W - 1){1'b0}}, 1'b1});
                    full_error_next = 1'b0;
                    count_next      = count_reg + 1'b1;
                    total_next      = count_next;
                    work_next       = shift_res.rest;
                    rem_next        = rem_reg - 1'b1;
                    if (last_next) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    m_valid_next    = 1'b1;
                    out_byte_next   = 8'h00;
                    last_next       = 1'b1;
                    full_error_next = 1'b1;
                    total_next      = count_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            capacity_reg <= '1;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        work_reg       <= work_next;
        varint_reg     <= varint_next;
        len_reg        <= len_next;
        rem_reg        <= rem_next;
        fail_reg       <= fail_next;
        out_byte_reg   <= out_byte_next;
        last_reg       <= last_next;
        full_error_reg <= full_error_next;
        total_reg      <= total_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_last          = last_reg;
    assign m_full_error    = full_error_reg;
    assign m_total_written = total_reg;

    // An error transfer is always a single zero byte that ends its item.
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_full_error |-> m_last && (m_out_byte == 8'h00))
        else $error("error result is not a single zero byte");

    // The byte count only ever steps by one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg)) |->
            count_reg == $past(count_reg) + 1'b1)
        else $error("byte count moved by more than one");

    // Emitting starts only after a passing check.
    a_emit_after_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> !fail_reg && (rem_reg != '0))
        else $error("emitting without a passing capacity check");

    // The error path never touches the count.
    a_err_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ERR |=> $stable(count_reg))
        else $error("byte count changed on an error result");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for protobuf_scalar_wire_encoder.
// Predicts every encoded byte and capacity error, then checks the result stream under
// random idling and backpressure. Depends on pswe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module testbench
    import pswe_pkg::*;
();

    localparam int unsigned HALF_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES   = 4;
    // Longest item is a ten-byte varint: sized, checked, then emitted byte by byte.
    localparam int unsigned SETTLE_CYCLES  = 32;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned ENC_BYTES      = 10;

    localparam logic [MODE_W-1:0]  MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0]  MODE_UNUSED_HI = 3'd7;
    localparam logic [COUNT_W-1:0] CAPACITY_MAX   = '1;

    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic               full_error;
        logic [COUNT_W-1:0] total;
    } wire_byte_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_wr_en       = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data     = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [MODE_W-1:0]  s_mode          = '0;
    logic [VALUE_W-1:0] s_value         = '0;
    logic [FNUM_W-1:0]  s_field_number  = '0;
    logic [WT_W-1:0]    s_wire_type     = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [7:0]         m_out_byte;
    logic               m_last;
    logic               m_full_error;
    logic [COUNT_W-1:0] m_total_written;

    // Shadow copy of the encoder state.
    logic [COUNT_W-1:0] stream_capacity = CAPACITY_MAX;
    logic [COUNT_W-1:0] shadow_count    = '0;
    wire_byte_t         expected_bytes[$];

    logic        steady      = 1'b0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen   = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned stalled_cycles = 0;

    int unsigned err_count   = 0;
    int unsigned items_done  = 0;
    int unsigned bytes_seen  = 0;
    int unsigned full_seen   = 0;
    int unsigned cfg_writes  = 0;

    protobuf_scalar_wire_encoder uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_value        (s_value),
        .s_field_number (s_field_number),
        .s_wire_type    (s_wire_type),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last         (m_last),
        .m_full_error   (m_full_error),
        .m_total_written(m_total_written)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Builds the wire encoding of one item; returns its length, zero for an unused mode.
    function automatic int unsigned encode_field(
        input  logic [MODE_W-1:0]       mode,
        input  logic [VALUE_W-1:0]      value,
        input  logic [FNUM_W-1:0]       fnum,
        input  logic [WT_W-1:0]         wt,
        output logic [ENC_BYTES*8-1:0]  enc
    );
        logic [VALUE_W-1:0] v;
        int unsigned        n;
        enc = '0;
        n   = 0;
        v   = '0;
        case (mode)
            MODE_VARINT:  v = value;
            MODE_SVARINT: v = (value << 1) ^ {VALUE_W{value[VALUE_W-1]}};
            MODE_TAG:     v = (VALUE_W'(fnum) << 3) | VALUE_W'(wt);
            MODE_FIXED32, MODE_FIXED64: begin
                n = 32'((mode == MODE_FIXED32) ? LEN_FIXED32 : LEN_FIXED64);
                for (int i = 0; i < n; i++) enc[8*i +: 8] = value[8*i +: 8];
                return n;
            end
            default: return 0;
        endcase
        while (v > VALUE_W'(GROUP_MASK)) begin
            enc[8*n +: 8] = (v[7:0] & GROUP_MASK) | CONT_BIT;
            v = v >> 7;
            n++;
        end
        enc[8*n +: 8] = v[7:0];
        return n + 1;
    endfunction

    // Queues the results of one accepted item and advances the shadow byte count.
    function automatic void predict_item(
        input logic [MODE_W-1:0]  mode,
        input logic [VALUE_W-1:0] value,
        input logic [FNUM_W-1:0]  fnum,
        input logic [WT_W-1:0]    wt
    );
        logic [ENC_BYTES*8-1:0] enc;
        logic [COUNT_W:0]       sum;
        int unsigned            n;
        wire_byte_t             r;
        n = encode_field(mode, value, fnum, wt, enc);
        if (n == 0) return;
        items_done++;
        sum = {1'b0, shadow_count} + (COUNT_W + 1)'(n);
        if (sum[COUNT_W] || sum[COUNT_W-1:0] > stream_capacity) begin
            r = '{data: 8'h00, last: 1'b1, full_error: 1'b1, total: shadow_count};
            expected_bytes.push_back(r);
            return;
        end
        for (int k = 0; k < n; k++) begin
            shadow_count = shadow_count + 1'b1;
            r = '{data: enc[8*k +: 8], last: (k == n - 1), full_error: 1'b0,
                  total: shadow_count};
            expected_bytes.push_back(r);
        end
    endfunction

    task automatic send_item(
        input logic [MODE_W-1:0]  mode,
        input logic [VALUE_W-1:0] value,
        input logic [FNUM_W-1:0]  fnum,
        input logic [WT_W-1:0]    wt
    );
        if (!steady && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_value        <= value;
        s_field_number <= fnum;
        s_wire_type    <= wt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(mode, value, fnum, wt);
    endtask

    // Stops offering items and waits until the encoder has delivered everything.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [COUNT_W-1:0] cap);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en       <= 1'b0;
        stream_capacity = cap;
        cfg_writes++;
    endtask

    function automatic logic [VALUE_W-1:0] rand_operand();
        logic [VALUE_W-1:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return full;
            1:       return full >> $urandom_range(0, 63);
            2:       return ~(full >> $urandom_range(8, 63));
            default: return (64'd1 << (7 * $urandom_range(1, 9))) - $urandom_range(0, 1);
        endcase
    endfunction

    task automatic send_random_item();
        logic [MODE_W-1:0] mode;
        if ($urandom_range(0, 99) < 4)
            mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        else
            mode = MODE_W'($urandom_range(MODE_VARINT, MODE_TAG));
        send_item(mode, rand_operand(), FNUM_W'($urandom >> $urandom_range(0, 31)),
                  WT_W'($urandom));
    endtask

    task automatic test_varint_extremes();
        send_item(MODE_VARINT, 64'd0, '0, '0);
        send_item(MODE_VARINT, 64'h7F, '0, '0);
        send_item(MODE_VARINT, 64'h80, '0, '0);
        send_item(MODE_VARINT, '1, '0, '0);
        send_item(MODE_VARINT, 64'h8000_0000_0000_0000, '0, '0);
    endtask

    task automatic test_zigzag_extremes();
        send_item(MODE_SVARINT, 64'd0, '0, '0);
        send_item(MODE_SVARINT, '1, '0, '0);
        send_item(MODE_SVARINT, 64'h8000_0000_0000_0000, '0, '0);
        send_item(MODE_SVARINT, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    endtask

    task automatic test_fixed_widths();
        // The high word must not leak into a fixed32 encoding.
        send_item(MODE_FIXED32, 64'hDEAD_BEEF_1234_5678, '1, '1);
        send_item(MODE_FIXED64, '1, '0, '0);
        send_item(MODE_FIXED64, 64'h0123_4567_89AB_CDEF, '0, '0);
    endtask

    task automatic test_tags();
        send_item(MODE_TAG, '1, '0, '0);
        send_item(MODE_TAG, '0, '1, '1);
    endtask

    task automatic test_unused_modes();
        for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
            send_item(MODE_W'(m), '1, '1, '1);
    endtask

    task automatic test_capacity_limit();
        set_capacity(shadow_count + 3);
        send_item(MODE_VARINT, 64'h1_0000_0000, '0, '0);
        send_item(MODE_VARINT, 64'h3FFF, '0, '0);
        send_item(MODE_VARINT, 64'h3FFF, '0, '0);
        // Filling the stream to exactly its capacity is still allowed.
        send_item(MODE_VARINT, 64'h01, '0, '0);
        set_capacity('0);
        send_item(MODE_TAG, '0, 32'd1, 3'd2);
        set_capacity(CAPACITY_MAX);
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0:       set_capacity(CAPACITY_MAX);
                1:       set_capacity(shadow_count + $urandom_range(40, 400));
                default: set_capacity(shadow_count + $urandom_range(0, 12));
            endcase
            target = items_done + 55;
            while (items_done < target) send_random_item();
        end
        set_capacity(CAPACITY_MAX);
    endtask

    task automatic test_back_to_back();
        int unsigned target;
        steady <= 1'b1;
        target = items_done + 40;
        while (items_done < target) send_random_item();
        drain_results();
        steady <= 1'b0;
    endtask

    // The receiver stalls for a long stretch while items keep coming.
    task automatic test_output_stall();
        int unsigned target;
        hold_toggle <= ~hold_toggle;
        target = items_done + 24;
        while (items_done < target) send_random_item();
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen  <= hold_toggle;
            stall_left <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge aclk) begin
        wire_byte_t exp_byte;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result transfer: byte %0h last %0b error %0b total %0d",
                       m_out_byte, m_last, m_full_error, m_total_written);
                err_count++;
            end else begin
                exp_byte = expected_bytes.pop_front();
                bytes_seen++;
                if (exp_byte.full_error) full_seen++;
                if (m_out_byte !== exp_byte.data) begin
                    $error("out_byte: expected %0h, got %0h", exp_byte.data, m_out_byte);
                    err_count++;
                end
                if (m_last !== exp_byte.last) begin
                    $error("last: expected %0b, got %0b", exp_byte.last, m_last);
                    err_count++;
                end
                if (m_full_error !== exp_byte.full_error) begin
                    $error("full_error: expected %0b, got %0b", exp_byte.full_error,
                           m_full_error);
                    err_count++;
                end
                if (m_total_written !== exp_byte.total) begin
                    $error("total_written: expected %0d, got %0d", exp_byte.total,
                           m_total_written);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     stalled_cycles, expected_bytes.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_varint_extremes();
        test_zigzag_extremes();
        test_fixed_widths();
        test_tags();
        test_unused_modes();
        test_capacity_limit();
        test_random_traffic();
        test_back_to_back();
        test_output_stall();
        drain_results();

        $display("Encoded %0d items into %0d result transfers, %0d of them capacity errors,",
                 items_done, bytes_seen, full_seen);
        $display("across %0d capacity settings; final byte count %0d.", cfg_writes,
                 shadow_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
